// File: hdl/stable_merge_sorter_macros.svh
// assertion macros for the stable merge sorter checker
// expects clk and rst_n in the scope of each use
`ifndef STABLE_MERGE_SORTER_MACROS_SVH
`define STABLE_MERGE_SORTER_MACROS_SVH

// property checked outside reset
`define SMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stable_merge_sorter check failed");

// property that also spans the reset cycles
`define SMS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stable_merge_sorter reset check failed");

`endif

// File: hdl/smsort_pkg.sv
// shared types and constants for the stable merge sorter
// no dependencies
package smsort_pkg;

  // fixed width of the sample and sorted value ports
  localparam int SAMPLE_W = 32;

  // parameter defaults
  localparam int DEF_MAX_ITEMS  = 64;
  localparam int DEF_VALUE_BITS = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME0,
    ST_PRIME1,
    ST_MERGE,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/smsort_ram.sv
// simple dual-read memory: one write port, two registered read ports
// no dependencies
module smsort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_l,
  input  logic [AW-1:0]    raddr_r,
  output logic [WIDTH-1:0] rdata_l,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_l <= mem[raddr_l];
    rdata_r <= mem[raddr_r];
  end

endmodule

// File: hdl/stable_merge_sorter.sv
// stable merge sorter: loads one value per cycle while in ST_LOAD, then bottom-up merge
// passes ping-pong between two memories. Sorting n values takes ceil(log2 n) passes, with
// each run pair primed in ST_PRIME0 and then ST_PRIME1; the first result passes the
// memory read register and then the output register, then one result per cycle
// while out_ready is high. No new set is accepted until the last one has been emitted.
// Reset clears state, fill count, overflow flag and output valid; memories keep contents.
module stable_merge_sorter #(
  parameter int MAX_ITEMS  = smsort_pkg::DEF_MAX_ITEMS,
  parameter int VALUE_BITS = smsort_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [smsort_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_final_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smsort_pkg::SAMPLE_W-1:0] out_sorted_value,
  output logic                                out_run_end,
  output logic                                out_overflowed
);
  import smsort_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int FW = $clog2(MAX_ITEMS + 1);
  localparam int CW = $clog2(MAX_ITEMS) + 2;
  localparam logic [FW-1:0] MAX_CNT = FW'(MAX_ITEMS);

  state_t state_r, state_nxt;

  logic [FW-1:0]         fill_r, fill_nxt;
  logic                  drop_r, drop_nxt;
  logic                  src_sel_r, src_sel_nxt;
  logic [CW-1:0]         width_r, width_nxt;
  logic [CW-1:0]         lo_r, lo_nxt;
  logic [FW-1:0]         mid_r, mid_nxt;
  logic [FW-1:0]         hi_r, hi_nxt;
  logic [FW-1:0]         i_r, i_nxt;
  logic [FW-1:0]         j_r, j_nxt;
  logic [FW-1:0]         k_r, k_nxt;
  logic [VALUE_BITS-1:0] head_lf_r, head_lf_nxt;
  logic [VALUE_BITS-1:0] head_rt_r, head_rt_nxt;
  logic [FW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_value_r, out_value_nxt;
  logic                  out_end_r, out_end_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic [VALUE_BITS-1:0] load_val;
  logic [CW-1:0]         n_ext;
  logic [CW-1:0]         w2;
  logic [CW-1:0]         lo_w;
  logic [CW-1:0]         lo_2w;
  logic                  take_left;
  logic                  load_out;
  logic                  issue;

  logic                  a_we, b_we;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [AW-1:0]         rd_addr_l, rd_addr_r;
  logic [VALUE_BITS-1:0] a_rd_l, a_rd_r, b_rd_l, b_rd_r;
  logic [VALUE_BITS-1:0] src_l, src_r;

  // value store and merge scratch, used as ping-pong source and destination
  smsort_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .we      (a_we),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_l (rd_addr_l),
    .raddr_r (rd_addr_r),
    .rdata_l (a_rd_l),
    .rdata_r (a_rd_r)
  );

  smsort_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VALUE_BITS)
  ) u_scratch (
    .clk     (clk),
    .we      (b_we),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_l (rd_addr_l),
    .raddr_r (rd_addr_r),
    .rdata_l (b_rd_l),
    .rdata_r (b_rd_r)
  );

  // source side read data
  assign src_l = src_sel_r ? b_rd_l : a_rd_l;
  assign src_r = src_sel_r ? b_rd_r : a_rd_r;

  // bits above the value width are dropped, narrower samples zero-extend
  assign load_val = VALUE_BITS'($unsigned(in_sample));

  // run bounds
  assign n_ext = CW'(fill_r);
  assign w2    = {width_r[CW-2:0], 1'b0};
  assign lo_w  = lo_r + width_r;
  assign lo_2w = lo_r + w2;

  // left run wins ties to keep arrival order
  assign take_left = (j_r >= hi_r) ||
                     ((i_r < mid_r) && ($signed(head_lf_r) <= $signed(head_rt_r)));

  // emit side: move pending read data into the output register when free
  assign load_out = pend_r && (!out_valid_r || out_ready);
  assign issue    = (rd_ptr_r < fill_r) && (!pend_r || load_out);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, memory control and datapath updates
  // source and destination are always different memories during a pass,
  // and loading and emitting never overlap, so no read meets a write
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    src_sel_nxt   = src_sel_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    head_lf_nxt   = head_lf_r;
    head_rt_nxt   = head_rt_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    in_ready      = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    wr_addr       = fill_r[AW-1:0];
    wr_data       = load_val;
    rd_addr_l     = '0;
    rd_addr_r     = '0;

    unique case (state_r)
      // collect the set
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (fill_r < MAX_CNT) begin
            a_we     = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_final_item) begin
            src_sel_nxt = 1'b0;
            width_nxt   = CW'(1);
            lo_nxt      = '0;
            rd_ptr_nxt  = '0;
            pend_nxt    = 1'b0;
            state_nxt   = (fill_nxt > FW'(1)) ? ST_PRIME0 : ST_EMIT;
          end
        end
      end

      // set up a run pair and fetch both heads
      ST_PRIME0: begin
        mid_nxt   = (lo_w > n_ext) ? fill_r : lo_w[FW-1:0];
        hi_nxt    = (lo_2w > n_ext) ? fill_r : lo_2w[FW-1:0];
        i_nxt     = lo_r[FW-1:0];
        j_nxt     = mid_nxt;
        k_nxt     = lo_r[FW-1:0];
        rd_addr_l = lo_r[AW-1:0];
        rd_addr_r = mid_nxt[AW-1:0];
        state_nxt = ST_PRIME1;
      end

      // latch heads, prefetch the entries behind them
      ST_PRIME1: begin
        head_lf_nxt = src_l;
        head_rt_nxt = src_r;
        rd_addr_l   = AW'(i_r + 1'b1);
        rd_addr_r   = AW'(j_r + 1'b1);
        state_nxt   = ST_MERGE;
      end

      // one merged element per cycle
      ST_MERGE: begin
        wr_addr = k_r[AW-1:0];
        wr_data = take_left ? head_lf_r : head_rt_r;
        if (src_sel_r) begin
          a_we = 1'b1;
        end else begin
          b_we = 1'b1;
        end
        if (take_left) begin
          i_nxt       = i_r + 1'b1;
          head_lf_nxt = src_l;
        end else begin
          j_nxt       = j_r + 1'b1;
          head_rt_nxt = src_r;
        end
        k_nxt     = k_r + 1'b1;
        rd_addr_l = AW'(i_nxt + 1'b1);
        rd_addr_r = AW'(j_nxt + 1'b1);
        // end of run pair, then end of pass, then end of sort
        if (k_nxt == hi_r) begin
          if (lo_2w >= n_ext) begin
            src_sel_nxt = !src_sel_r;
            width_nxt   = w2;
            lo_nxt      = '0;
            if (w2 >= n_ext) begin
              rd_ptr_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = ST_EMIT;
            end else begin
              state_nxt = ST_PRIME0;
            end
          end else begin
            lo_nxt    = lo_2w;
            state_nxt = ST_PRIME0;
          end
        end
      end

      // stream sorted values out of the result memory
      ST_EMIT: begin
        rd_addr_l = issue ? rd_ptr_r[AW-1:0] : AW'(rd_ptr_r - 1'b1);
        if (issue) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        pend_nxt = issue || (pend_r && !load_out);
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = SAMPLE_W'(src_l);
          out_end_nxt   = (rd_ptr_r == fill_r);
          out_ovf_nxt   = drop_r;
        end
        if ((rd_ptr_nxt == fill_r) && !pend_nxt) begin
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      src_sel_r   <= 1'b0;
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      src_sel_r   <= src_sel_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    head_lf_r   <= head_lf_nxt;
    head_rt_r   <= head_rt_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // result request
  assign out_valid        = out_valid_r;
  assign out_sorted_value = $signed(out_value_r);
  assign out_run_end      = out_end_r;
  assign out_overflowed   = out_ovf_r;

endmodule

// File: hdl/smsort_checker.sv
// port-level checks for the stable merge sorter, bound to the top level
// depends on smsort_pkg and stable_merge_sorter_macros.svh
`include "stable_merge_sorter_macros.svh"

module smsort_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_final_item,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [smsort_pkg::SAMPLE_W-1:0] out_sorted_value,
  input logic                                out_run_end,
  input logic                                out_overflowed
);
  import smsort_pkg::*;

  logic mid_set_r;
  logic prev_ovf_r;

  // track whether the last result request left a set open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_set_r  <= 1'b0;
      prev_ovf_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_set_r  <= !out_run_end;
      prev_ovf_r <= out_overflowed;
    end
  end

  // stalled result request holds
  `SMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sorted_value) && $stable(out_run_end))

  // closing a set stops intake while it sorts
  `SMS_ASSERT(a_final_stops_input, in_valid && in_ready && in_final_item |=> !in_ready)

  // overflow flag is the same on every result of a set
  `SMS_ASSERT(a_ovf_per_set, out_valid && out_ready && mid_set_r |-> out_overflowed == prev_ovf_r)

  // no result right after reset
  `SMS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid)

endmodule

bind stable_merge_sorter smsort_checker u_smsort_checker (.*);
